@@ hdl/htfl_pkg.sv @@
// Shared constants and codes for the handle table with its embedded free list.
// Used by handle_table_free_list; the generic RAM htfl_ram is independent of it.
`default_nettype none

package htfl_pkg;

  localparam int CAPACITY  = 16;
  localparam int REF_WIDTH = 32;

  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ACTION_W = 2;
  localparam int HANDLE_W = 5;
  localparam int STATUS_W = 2;

  localparam int IN_BITS   = ACTION_W + HANDLE_W + REF_WIDTH;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = HANDLE_W + REF_WIDTH + STATUS_W + CNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_RESERVE = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_LOOKUP  = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_BAD_HANDLE = 2'd2
  } status_t;

endpackage

`default_nettype wire

@@ hdl/htfl_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; the contents are not reset.
`default_nettype none

module htfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/handle_table_free_list.sv @@
// Top level of the handle table: request and result channels, control FSM and
// free-list bookkeeping. Depends on htfl_pkg and the entry memory htfl_ram.
//
// Usage: a request arrives on the s_ group (action, handle, reference) and
// produces exactly one result on the m_ group (granted handle, looked-up
// reference, status, handles in use). Reserve pops the head of the free list
// and grants a one-based handle, release pushes the entry back on the head,
// lookup returns the entry's contents.
// The request is registered when it is taken, and the result is registered
// at the end of the execute step. Requests do not overlap: a new one is taken
// only when idle, as the entry memory's registered read of the next-free link
// (or of the looked-up entry) must come before the entry can be updated.
// The result register decouples the channels: a new request is taken while
// an earlier result still waits. If the receiver stalls with a result held,
// the next request waits in the execute step until the result is taken.
// Reset: synchronous. All entries become free and chained in order, the
// free-list head points at entry 0 and no handle is in use. No clearing pass
// is needed; per-entry valid bits supply the reset contents.
`default_nettype none

module handle_table_free_list
  import htfl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // action [1:0], handle [6:2], reference [38:7], zero fill above
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // out_handle [4:0], out_reference [36:5], status [38:37], in_use [43:39],
  // zero fill above
  output logic      [OUT_DATA_W-1:0] m_tdata
);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t               state;
  action_t              act_q;
  logic [HANDLE_W-1:0]  handle_q;
  logic [REF_WIDTH-1:0] ref_q;
  logic [IDX_W-1:0]     rd_idx;
  logic                 rd_valid;
  logic [CNT_W-1:0]     free_head;
  logic [CNT_W-1:0]     used_count;
  logic [CAPACITY-1:0]  entry_valid;

  logic [HANDLE_W-1:0]  res_handle;
  logic [REF_WIDTH-1:0] res_ref;
  status_t              res_status;

  logic                 s_accept;
  logic                 exec_go;
  logic [IDX_W-1:0]     req_idx;
  action_t              req_act;
  logic [HANDLE_W-1:0]  req_handle;
  logic [REF_WIDTH-1:0] ram_rdata;
  logic [REF_WIDTH-1:0] entry_data;
  logic                 ram_we;
  logic [REF_WIDTH-1:0] ram_wdata;
  logic [CNT_W-1:0]     free_head_next;
  logic [CNT_W-1:0]     used_count_next;
  logic [HANDLE_W-1:0]  res_handle_next;
  logic [REF_WIDTH-1:0] res_ref_next;
  status_t              res_status_next;
  logic                 bad_handle;

  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign exec_go  = (state == ST_EXEC) && (!m_tvalid || m_tready);

  assign req_act    = action_t'(s_tdata[ACTION_W-1:0]);
  assign req_handle = s_tdata[ACTION_W +: HANDLE_W];
  // Reserve reads the head entry for its link, the others the handle's entry.
  assign req_idx    = (req_act == ACT_RESERVE) ? free_head[IDX_W-1:0]
                                               : IDX_W'(req_handle - HANDLE_W'(1));

  htfl_ram #(
    .WIDTH (REF_WIDTH),
    .DEPTH (CAPACITY)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rd_idx),
    .wdata (ram_wdata),
    .re    (s_accept),
    .raddr (req_idx),
    .rdata (ram_rdata)
  );

  // An entry never written since reset still holds its reset link, index+1.
  assign entry_data = rd_valid ? ram_rdata
                               : REF_WIDTH'({1'b0, rd_idx}) + REF_WIDTH'(1);

  assign bad_handle = (handle_q == '0) || (handle_q > HANDLE_W'(CAPACITY));

  always_comb begin
    ram_we          = 1'b0;
    ram_wdata       = ref_q;
    free_head_next  = free_head;
    used_count_next = used_count;
    res_handle_next = '0;
    res_ref_next    = '0;
    res_status_next = STAT_OK;
    unique case (act_q)
      ACT_RESERVE: begin
        if (used_count >= CNT_W'(CAPACITY) || free_head >= CNT_W'(CAPACITY)) begin
          res_status_next = STAT_FULL;
        end else begin
          ram_we          = exec_go;
          ram_wdata       = ref_q;
          free_head_next  = (entry_data >= REF_WIDTH'(CAPACITY)) ? CNT_W'(CAPACITY)
                                                                 : entry_data[CNT_W-1:0];
          used_count_next = used_count + CNT_W'(1);
          res_handle_next = HANDLE_W'({1'b0, rd_idx}) + HANDLE_W'(1);
        end
      end
      ACT_RELEASE: begin
        if (bad_handle || used_count == '0) begin
          res_status_next = STAT_BAD_HANDLE;
        end else begin
          ram_we          = exec_go;
          ram_wdata       = REF_WIDTH'(free_head);
          free_head_next  = CNT_W'(rd_idx);
          used_count_next = used_count - CNT_W'(1);
        end
      end
      ACT_LOOKUP: begin
        if (bad_handle) begin
          res_status_next = STAT_BAD_HANDLE;
        end else begin
          res_ref_next = entry_data;
        end
      end
      ACT_NONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      m_tvalid    <= 1'b0;
      free_head   <= '0;
      used_count  <= '0;
      entry_valid <= '0;
    end else begin
      if (m_tvalid && m_tready && !exec_go) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_accept) begin
            act_q    <= req_act;
            handle_q <= req_handle;
            ref_q    <= s_tdata[ACTION_W + HANDLE_W +: REF_WIDTH];
            rd_idx   <= req_idx;
            rd_valid <= entry_valid[req_idx];
            state    <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_go) begin
            free_head  <= free_head_next;
            used_count <= used_count_next;
            if (ram_we) begin
              entry_valid[rd_idx] <= 1'b1;
            end
            res_handle <= res_handle_next;
            res_ref    <= res_ref_next;
            res_status <= res_status_next;
            m_tvalid   <= 1'b1;
            state      <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign m_tdata = OUT_DATA_W'({used_count, res_status, res_ref, res_handle});

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CNT_W'(CAPACITY))
    else $error("handles in use exceed the table capacity");

  a_write_in_exec: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_EXEC) && exec_go)
    else $error("entry memory written outside the execute step");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> (state == ST_EXEC))
    else $error("accepted request did not enter the execute step");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) && !$past(rst) |=> $stable(used_count) || exec_go)
    else $error("handle count changed without a request being executed");

  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res_handle != '0) |-> (res_status == STAT_OK))
    else $error("granted handle carries a failure status");
`endif

endmodule

`default_nettype wire
